FILE: rtl/sgdm_pkg.sv
package sgdm_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_GRAD_SCALE = 3'd0,
		REG_DECAY_RATE = 3'd1,
		REG_BETA       = 3'd2,
		REG_OMB        = 3'd3,
		REG_STEP       = 3'd4
	} reg_idx_t;

	localparam logic [31:0] GRAD_SCALE_RST = 32'h3CF5C28F;
	localparam logic [31:0] DECAY_RATE_RST = 32'h3A83126F;
	localparam logic [31:0] BETA_RST       = 32'h3F666666;
	localparam logic [31:0] OMB_RST        = 32'h3DCCCCD0;
	localparam logic [31:0] STEP_RST       = 32'hBA83126F;
	localparam logic [31:0] CANON_NAN      = 32'h7FC00000;

	// unpacked operand: class flags, sign, unbiased exponent, 24-bit significand
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [9:0]  exp;
		logic [23:0]        sig;
	} fp_unp_t;

	// product or sum before rounding: value = sig * 2^(exp), sig carries sticky in lsb
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [10:0] exp;
		logic [49:0]        sig;
	} fp_raw_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] b);
		fp_unp_t u;
		u.sgn  = b[31];
		u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		u.zero = (b[30:0] == 31'd0);
		if (b[30:23] == 8'd0) begin
			u.exp = -10'sd126;
			u.sig = {1'b0, b[22:0]};
		end else begin
			u.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
			u.sig = {1'b1, b[22:0]};
		end
		return u;
	endfunction

	// exact binary16 to binary32 widening
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [31:0] o;
		logic [9:0]  m;
		logic [7:0]  e;
		integer      k;
		integer      i;
		o = 32'd0;
		m = h[9:0];
		e = 8'd0;
		k = 0;
		if (h[14:10] == 5'h1F) begin
			o = {1'b0, 8'hFF, m, 13'd0};
			if (m != 10'd0) o[22] = 1'b1;
		end else if (h[14:10] == 5'd0) begin
			if (m != 10'd0) begin
				for (i = 9; i >= 0; i--) begin
					if (m[i] && k == 0) k = 10 - i;
				end
				m = m << k;
				e = 8'd113 - 8'(k);
				o = {1'b0, e, m, 13'd0};
			end
		end else begin
			o = {1'b0, 3'b000, h[14:10], 23'd0} + {1'b0, 8'd112, 23'd0} +
				{9'd0, h[9:0], 13'd0};
		end
		o[31] = h[15];
		return o;
	endfunction

	// round a raw value to binary32, nearest-even, subnormals kept
	function automatic logic [31:0] fp_round(input fp_raw_t r);
		logic [49:0]        s;
		logic signed [11:0] e;
		logic [5:0]         lz;
		logic [5:0]         sh;
		logic [26:0]        t;
		logic               st;
		logic [24:0]        mr;
		logic signed [11:0] be;
		logic [31:0]        o;
		integer             i;
		s  = r.sig;
		lz = 6'd0;
		for (i = 0; i < 50; i++) begin
			if (s[i]) lz = 6'(49 - i);
		end
		if (r.nan) return CANON_NAN;
		if (r.inf) return {r.sgn, 8'hFF, 23'd0};
		if (r.zero || s == 50'd0) return {r.sgn, 31'd0};
		s = s << lz;
		// leading one now at bit 49: value = 1.x * 2^(e)
		e = 12'(r.exp) + 12'sd49 - 12'(lz);
		be = e + 12'sd127;
		if (be < 12'sd1) begin
			sh = (12'sd1 - be > 12'sd40) ? 6'd40 : 6'(12'sd1 - be);
			st = |(s & ~({50{1'b1}} << sh));
			s  = (s >> sh) | {49'd0, st};
			be = 12'sd0;
		end
		t  = {s[49:24], |s[23:0]};
		mr = {1'b0, t[26:3]};
		if (t[2] && (t[1] || t[0] || t[3])) mr = mr + 25'd1;
		if (mr[24]) begin
			mr = mr >> 1;
			be = be + 12'sd1;
		end else if (be == 12'sd0 && mr[23]) begin
			be = 12'sd1;
		end
		if (be >= 12'sd255) o = {r.sgn, 8'hFF, 23'd0};
		else o = {r.sgn, be[7:0], mr[22:0]};
		return o;
	endfunction

endpackage

FILE: rtl/sgdm_fmul.sv
// binary32 multiply, two register stages (product, rounded result)
module sgdm_fmul import sgdm_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fp_unp_t ua, ub;
	fp_raw_t raw_s1;
	logic [31:0] y_s2;
	logic [47:0] prod;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	// full 48-bit significand product
	assign prod = ua.sig * ub.sig;

	// stage 1: 24x24 significand product and exponent
	always_ff @(posedge clk) begin
		raw_s1.sgn  <= ua.sgn ^ ub.sgn;
		raw_s1.nan  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
		raw_s1.inf  <= ua.inf | ub.inf;
		raw_s1.zero <= ua.zero | ub.zero;
		raw_s1.exp  <= 11'(ua.exp) + 11'(ub.exp) - 11'sd46;
		raw_s1.sig  <= {2'b00, prod};
	end

	// stage 2: normalize and round
	always_ff @(posedge clk) begin
		y_s2 <= fp_round(raw_s1);
	end

	assign y = y_s2;

endmodule

FILE: rtl/sgdm_fadd.sv
// binary32 add, two register stages (aligned sum, rounded result)
module sgdm_fadd import sgdm_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fp_unp_t ua, ub, big, sml;
	fp_raw_t raw_s1;
	logic [31:0] y_s2;
	logic [9:0]  d;
	logic [5:0]  sh;
	logic [49:0] bs, ss, ssh;
	logic        st;
	logic        swap;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	// align the smaller operand, keep a sticky bit
	always_comb begin
		swap = (ub.exp > ua.exp) || ((ub.exp == ua.exp) && (ub.sig > ua.sig));
		big  = swap ? ub : ua;
		sml  = swap ? ua : ub;
		d    = 10'(big.exp - sml.exp);
		sh   = (d > 10'd40) ? 6'd40 : d[5:0];
		bs   = {1'b0, big.sig, 25'd0};
		ss   = {1'b0, sml.sig, 25'd0};
		st   = |(ss & ~({50{1'b1}} << sh));
		ssh  = (ss >> sh) | {49'd0, st};
	end

	// stage 1: add or subtract magnitudes, handle specials
	always_ff @(posedge clk) begin
		raw_s1.nan  <= ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn ^ ub.sgn));
		raw_s1.inf  <= ua.inf | ub.inf;
		raw_s1.exp  <= 11'(big.exp) - 11'sd48;
		if (ua.inf | ub.inf) begin
			raw_s1.sgn  <= ua.inf ? ua.sgn : ub.sgn;
			raw_s1.zero <= 1'b0;
			raw_s1.sig  <= bs;
		end else if (big.sgn == sml.sgn) begin
			raw_s1.sgn  <= big.sgn;
			raw_s1.zero <= ua.zero & ub.zero;
			raw_s1.sig  <= bs + ssh;
		end else begin
			raw_s1.sgn  <= (bs == ssh) ? 1'b0 : big.sgn;
			raw_s1.zero <= (bs == ssh);
			raw_s1.sig  <= bs - ssh;
		end
	end

	always_ff @(posedge clk) begin
		y_s2 <= fp_round(raw_s1);
	end

	assign y = y_s2;

endmodule

FILE: rtl/sgd_momentum_update.sv
// Channel  | Ports                                       | Handshake
// input    | grad_half param_in momentum_in last_in      | start & !busy
// config   | cfg_we cfg_idx cfg_data                     | cfg_we
// result   | param_out momentum_out last_out             | done, one cycle
//
// One item per clock; busy is always low. The path from the accepting edge to
// the edge that takes the result is one input register, then six dependent fp32
// ops (scale mul with the decay mul beside it, gradient add, one-minus-beta mul,
// momentum add, step mul, param add). Reset clears the valid bits and loads the
// register defaults; data stages are not reset.
// The receiver cannot stall; results are driven with done for one cycle.
module sgd_momentum_update import sgdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] grad_half,
	input  logic [31:0] param_in,
	input  logic [31:0] momentum_in,
	input  logic        last_in,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [31:0] param_out,
	output logic [31:0] momentum_out,
	output logic        last_out
);

	localparam int Lat = 13;

	logic [31:0] grad_scale_q, decay_rate_q, beta_q, omb_q, step_q;
	logic [31:0] g0_s1, p_s1, m_s1;
	logic        v_s1;
	logic [31:0] gs, pd, g, a, bm, mn, u, pn;
	logic [Lat-2:0]      vld_q;
	logic [Lat-1:0]      lst_q;
	logic [31:0] p_dly_q[10];
	logic [31:0] mb_dly_q[4];
	logic [31:0] mn_dly_q[4];

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_scale_q <= GRAD_SCALE_RST;
			decay_rate_q <= DECAY_RATE_RST;
			beta_q       <= BETA_RST;
			omb_q        <= OMB_RST;
			step_q       <= STEP_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_GRAD_SCALE: grad_scale_q <= cfg_data;
				REG_DECAY_RATE: decay_rate_q <= cfg_data;
				REG_BETA:       beta_q <= cfg_data;
				REG_OMB:        omb_q <= cfg_data;
				REG_STEP:       step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register with widening
	always_ff @(posedge clk) begin
		g0_s1 <= half_to_single(grad_half);
		p_s1  <= param_in;
		m_s1  <= momentum_in;
	end

	// t0 = s1 out; chain: gs and pd, then g, then a, then mn, then u, then pn
	sgdm_fmul u_mgs (.clk(clk), .a(g0_s1), .b(grad_scale_q), .y(gs));
	sgdm_fmul u_mpd (.clk(clk), .a(p_s1), .b(decay_rate_q), .y(pd));
	sgdm_fadd u_ag  (.clk(clk), .a(pd), .b(gs), .y(g));
	sgdm_fmul u_ma  (.clk(clk), .a(g), .b(omb_q), .y(a));
	sgdm_fmul u_mb  (.clk(clk), .a(m_s1), .b(beta_q), .y(bm));
	sgdm_fadd u_am  (.clk(clk), .a(a), .b(mb_dly_q[3]), .y(mn));
	sgdm_fmul u_mu  (.clk(clk), .a(mn), .b(step_q), .y(u));
	sgdm_fadd u_ap  (.clk(clk), .a(u), .b(p_dly_q[9]), .y(pn));

	// delay lines: beta product to meet a, param to meet u, new momentum to meet pn
	always_ff @(posedge clk) begin
		mb_dly_q[0] <= bm;
		for (int k = 1; k < 4; k++) mb_dly_q[k] <= mb_dly_q[k-1];
		p_dly_q[0]  <= p_s1;
		for (int i = 1; i < 10; i++) p_dly_q[i] <= p_dly_q[i-1];
		mn_dly_q[0] <= mn;
		for (int j = 1; j < 4; j++) mn_dly_q[j] <= mn_dly_q[j-1];
	end

	// valid and last travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1  <= start & ~busy;
			vld_q <= {vld_q[Lat-3:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		lst_q <= {lst_q[Lat-2:0], last_in};
	end

	assign done         = vld_q[Lat-2];
	assign last_out     = lst_q[Lat-1];
	assign param_out    = pn;
	assign momentum_out = mn_dly_q[3];

	// no output without an earlier accepted item
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 13)) else $error("result without item");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy) else $error("busy raised");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> last_out == $past(last_in, 13)) else $error("last flag lost");

endmodule
